// ----- hdl/isaac_pkg.sv -----
// ----------------------------------------------------------------------------
// ISAAC package
// Shared constants, types and the mixing function of the ISAAC generator.
// ----------------------------------------------------------------------------
`default_nettype none
package isaac_pkg;
  localparam int unsigned SizeLog2Default = 8;
  localparam logic [31:0] Golden = 32'h9e3779b9;

  typedef enum logic [0:0] {
    FUNC_SEED = 1'b0,
    FUNC_DRAW = 1'b1
  } func_t;

  typedef struct packed {
    logic        valid;
    func_t       func;
    logic [31:0] seed;
  } cmd_t;

  typedef logic [7:0][31:0] vec8_t;

  // One row of the eight-word mix; rows 0 to 7 in order make a full mix.
  function automatic vec8_t mix_row(input vec8_t vi, input logic [2:0] row);
    vec8_t v;
    logic [31:0] s;
    logic [2:0] p1, p2, p3;
    v = vi;
    p1 = row + 3'd1;
    p2 = row + 3'd2;
    p3 = row + 3'd3;
    case (row)
      3'd0: s = v[p1] << 11;
      3'd1: s = v[p1] >> 2;
      3'd2: s = v[p1] << 8;
      3'd3: s = v[p1] >> 16;
      3'd4: s = v[p1] << 10;
      3'd5: s = v[p1] >> 4;
      3'd6: s = v[p1] << 8;
      default: s = v[p1] >> 9;
    endcase
    v[row] = v[row] ^ s;
    v[p3] = v[p3] + v[row];
    v[p1] = v[p1] + v[p2];
    return v;
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLEAR, ST_SEXP, ST_GMIX, ST_P_RD, ST_P_WAIT, ST_P_LOAD, ST_P_MIX,
    ST_P_WR, ST_R_INIT, ST_R_A, ST_R_B, ST_R_C, ST_R_D, ST_R_E, ST_D_RD, ST_D_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- hdl/isaac_random_generator_core.sv -----
// ----------------------------------------------------------------------------
// ISAAC random generator core
// 32-bit ISAAC generator with seeding and one word per draw command.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; a two-beat queue
// holds them in front of the engine. in_func selects a reseed from
// in_seed_value or a draw. A draw returns one beat on out_random_value,
// marked by out_valid for one cycle; the receiver cannot stall it.
// A draw served from the result buffer passes through ST_D_RD and ST_D_OUT
// before its registered beat, and the engine is then free for the next command.
// A draw that finds the buffer empty first runs a round over the
// single-port word memory: a setup state, then ST_R_A to ST_R_E for each
// word, then serves the draw. A reseed expands the seed into the result
// buffer, scrambles the golden-ratio vector, makes two mix passes over
// groups of eight words, then runs one round, and returns nothing.
// After reset a clearing pass zeroes every word of both memories;
// commands queue in the meantime.
// ----------------------------------------------------------------------------
`default_nettype none
module isaac_random_generator_core
  import isaac_pkg::*;
#(
  parameter int unsigned SIZE_LOG2 = SizeLog2Default
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [31:0] in_seed_value,
  output logic             out_valid,
  output logic [31:0]      out_random_value
);
  cmd_t head;
  logic pop;

  isaac_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_func(in_func),
    .in_seed_value(in_seed_value), .busy(busy), .pop(pop), .head(head));

  isaac_engine #(.SizeLog2(SIZE_LOG2)) u_engine (
    .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
    .out_valid(out_valid), .out_random_value(out_random_value));
endmodule
`default_nettype wire

// ----- hdl/isaac_ram.sv -----
// ----------------------------------------------------------------------------
// ISAAC RAM
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module isaac_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- hdl/isaac_front.sv -----
// ----------------------------------------------------------------------------
// ISAAC front end
// Accepts command beats and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module isaac_front
  import isaac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        in_func,
  input  wire logic [31:0] in_seed_value,
  output logic             busy,
  input  wire logic        pop,
  output cmd_t             head
);
  cmd_t q_r [2];
  cmd_t q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic push;
  cmd_t c;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign c.valid = 1'b1;
  assign c.func = func_t'(in_func);
  assign c.seed = in_seed_value;
  assign head = cnt_r != 2'd0 ? q_r[0] : '0;

  always_comb begin
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    if (pop && cnt_r != 2'd0) begin
      q_nxt[0] = q_r[1];
      cnt_nxt = cnt_nxt - 2'd1;
    end
    if (push) begin
      q_nxt[cnt_nxt[0]] = c;
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count lost a beat");
  assert property (@(posedge clk) disable iff (!rst_n) head.valid == (cnt_r != 2'd0))
    else $error("head valid mismatch");
endmodule
`default_nettype wire

// ----- hdl/isaac_engine.sv -----
// ----------------------------------------------------------------------------
// ISAAC engine
// Seeds, mixes and runs ISAAC rounds over the two word memories; serves draws.
// ----------------------------------------------------------------------------
`default_nettype none
module isaac_engine
  import isaac_pkg::*;
#(
  parameter int unsigned SizeLog2 = SizeLog2Default
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cmd_t             head,
  output logic             pop,
  output logic             out_valid,
  output logic [31:0]      out_random_value
);
  localparam int unsigned Words = 1 << SizeLog2;
  localparam int unsigned AW = SizeLog2;

  state_t st_r, st_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [2:0] k_r, k_nxt;
  logic [1:0] g_r, g_nxt;
  logic pass_r, pass_nxt;
  vec8_t v_r, v_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, cnt_r, cnt_nxt, lb_r, lb_nxt;
  logic [31:0] x_r, x_nxt, w_r, w_nxt;
  logic [AW:0] left_r, left_nxt;
  logic [31:0] ov_r, ov_nxt;
  logic ovl_r, ovl_nxt;

  logic m_we, r_we;
  logic [AW-1:0] m_addr, r_addr;
  logic [31:0] m_wd, r_wd, m_rd, r_rd;
  logic [31:0] t;

  isaac_ram #(.Width(32), .Depth(Words)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));
  isaac_ram #(.Width(32), .Depth(Words)) u_res (
    .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wd), .rdata(r_rd));

  always_comb begin
    case (i_r[1:0])
      2'd0: t = a_r << 13;
      2'd1: t = a_r >> 6;
      2'd2: t = a_r << 2;
      default: t = a_r >> 16;
    endcase
  end

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; k_nxt = k_r; g_nxt = g_r; pass_nxt = pass_r;
    v_nxt = v_r; a_nxt = a_r; b_nxt = b_r; cnt_nxt = cnt_r; lb_nxt = lb_r;
    x_nxt = x_r; w_nxt = w_r; left_nxt = left_r; ov_nxt = ov_r; ovl_nxt = 1'b0;
    m_we = 1'b0; r_we = 1'b0; m_addr = i_r; r_addr = i_r; m_wd = '0; r_wd = '0;
    pop = 1'b0;
    case (st_r)
      ST_CLEAR: begin
        m_we = 1'b1; r_we = 1'b1;
        i_nxt = i_r + AW'(1);
        if (i_r == AW'(Words - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          i_nxt = '0;
          if (head.func == FUNC_SEED) begin
            w_nxt = head.seed;
            st_nxt = ST_SEXP;
          end else if (left_r == '0) begin
            st_nxt = ST_R_INIT;
          end else begin
            left_nxt = left_r - (AW+1)'(1);
            st_nxt = ST_D_RD;
          end
        end
      end
      ST_SEXP: begin
        r_we = 1'b1; r_wd = w_r;
        w_nxt = (w_r + 32'd1) * w_r;
        i_nxt = i_r + AW'(1);
        if (i_r == AW'(Words - 1)) begin
          a_nxt = '0; lb_nxt = '0; cnt_nxt = '0;
          v_nxt = {8{Golden}}; g_nxt = '0; k_nxt = '0; st_nxt = ST_GMIX;
        end
      end
      ST_GMIX: begin
        v_nxt = mix_row(v_r, k_r);
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd7) begin
          g_nxt = g_r + 2'd1;
          if (g_r == 2'd3) begin
            i_nxt = '0; pass_nxt = 1'b0; st_nxt = ST_P_RD;
          end
        end
      end
      ST_P_RD: begin
        m_addr = i_r | AW'(k_r); r_addr = i_r | AW'(k_r);
        st_nxt = ST_P_WAIT;
      end
      ST_P_WAIT: begin
        m_addr = i_r | AW'(k_r); r_addr = i_r | AW'(k_r);
        st_nxt = ST_P_LOAD;
      end
      ST_P_LOAD: begin
        v_nxt[k_r] = v_r[k_r] + (pass_r ? m_rd : r_rd);
        k_nxt = k_r + 3'd1;
        st_nxt = (k_r == 3'd7) ? ST_P_MIX : ST_P_RD;
      end
      ST_P_MIX: begin
        v_nxt = mix_row(v_r, k_r);
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd7) st_nxt = ST_P_WR;
      end
      ST_P_WR: begin
        m_we = 1'b1; m_addr = i_r | AW'(k_r); m_wd = v_r[k_r];
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd7) begin
          i_nxt = i_r + AW'(8);
          st_nxt = ST_P_RD;
          if (i_r == AW'(Words - 8)) begin
            pass_nxt = 1'b1;
            if (pass_r) st_nxt = ST_R_INIT;
          end
        end
      end
      ST_R_INIT: begin
        cnt_nxt = cnt_r + 32'd1;
        b_nxt = lb_r + cnt_r + 32'd1;
        i_nxt = '0;
        st_nxt = ST_R_A;
      end
      ST_R_A: begin
        m_addr = i_r;
        st_nxt = ST_R_B;
      end
      ST_R_B: begin
        x_nxt = m_rd;
        m_addr = i_r + AW'(Words / 2);
        st_nxt = ST_R_C;
      end
      ST_R_C: begin
        a_nxt = (a_r ^ t) + m_rd;
        m_addr = x_r[AW+1:2];
        st_nxt = ST_R_D;
      end
      ST_R_D: begin
        w_nxt = m_rd + a_r + b_r;
        m_we = 1'b1; m_addr = i_r; m_wd = m_rd + a_r + b_r;
        st_nxt = ST_R_E;
      end
      ST_R_E: begin
        m_addr = w_r[2*AW+1:AW+2];
        st_nxt = ST_R_E;
        if (k_r == 3'd0) begin
          k_nxt = 3'd1;
        end else begin
          k_nxt = 3'd0;
          b_nxt = m_rd + x_r;
          r_we = 1'b1; r_addr = i_r; r_wd = m_rd + x_r;
          i_nxt = i_r + AW'(1);
          st_nxt = ST_R_A;
          if (i_r == AW'(Words - 1)) begin
            lb_nxt = m_rd + x_r;
            st_nxt = ST_IDLE;
            if (pass_r) begin
              left_nxt = (AW+1)'(Words);
              pass_nxt = 1'b0;
            end else begin
              left_nxt = (AW+1)'(Words - 1);
              st_nxt = ST_D_RD;
            end
          end
        end
      end
      ST_D_RD: begin
        r_addr = left_r[AW-1:0];
        st_nxt = ST_D_OUT;
      end
      ST_D_OUT: begin
        r_addr = left_r[AW-1:0];
        ovl_nxt = 1'b1; ov_nxt = r_rd;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ovl_r;
  assign out_random_value = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; i_r <= '0; k_r <= '0; g_r <= '0; pass_r <= 1'b0;
      a_r <= '0; b_r <= '0; cnt_r <= '0; lb_r <= '0; left_r <= '0; ovl_r <= 1'b0;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt; k_r <= k_nxt; g_r <= g_nxt; pass_r <= pass_nxt;
      a_r <= a_nxt; b_r <= b_nxt; cnt_r <= cnt_nxt; lb_r <= lb_nxt;
      left_r <= left_nxt; ovl_r <= ovl_nxt;
    end
    v_r <= v_nxt; x_r <= x_nxt; w_r <= w_nxt; ov_r <= ov_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) left_r <= (AW+1)'(Words))
    else $error("result count out of range");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $past(st_r) == ST_D_OUT)
    else $error("result beat without draw");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> st_r == ST_IDLE)
    else $error("command taken while working");
endmodule
`default_nettype wire

// ----- sim/isaac_random_generator_core_tb.sv -----
// ----------------------------------------------------------------------------
// ISAAC random generator core testbench
// Drives seed and draw commands through the start/busy handshake, predicts
// every random word with an independent ISAAC model, and compares each
// out_valid beat against the oldest predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module isaac_random_generator_core_tb;
  import isaac_pkg::*;

  localparam int unsigned WordsLog2 = 8;
  localparam int unsigned Words = 1 << WordsLog2;
  localparam int unsigned StallLimit = 50000;

  class isaac_scoreboard;
    logic [31:0] mem [Words];
    logic [31:0] rsl [Words];
    logic [31:0] aa, bb, cc;
    int unsigned left;
    logic [31:0] pending_words[$];
    int unsigned errors;

    function new();
      foreach (mem[i]) begin
        mem[i] = '0;
        rsl[i] = '0;
      end
      aa = '0; bb = '0; cc = '0; left = 0; errors = 0;
    endfunction

    function void scramble(ref logic [31:0] v[8]);
      v[0] ^= v[1] << 11; v[3] += v[0]; v[1] += v[2];
      v[1] ^= v[2] >> 2;  v[4] += v[1]; v[2] += v[3];
      v[2] ^= v[3] << 8;  v[5] += v[2]; v[3] += v[4];
      v[3] ^= v[4] >> 16; v[6] += v[3]; v[4] += v[5];
      v[4] ^= v[5] << 10; v[7] += v[4]; v[5] += v[6];
      v[5] ^= v[6] >> 4;  v[0] += v[5]; v[6] += v[7];
      v[6] ^= v[7] << 8;  v[1] += v[6]; v[7] += v[0];
      v[7] ^= v[0] >> 9;  v[2] += v[7]; v[0] += v[1];
    endfunction

    function void next_round();
      logic [31:0] a, b, x, y, t;
      a = aa;
      cc += 1;
      b = bb + cc;
      for (int i = 0; i < Words; i++) begin
        x = mem[i];
        case (i % 4)
          0: t = a << 13;
          1: t = a >> 6;
          2: t = a << 2;
          default: t = a >> 16;
        endcase
        a = (a ^ t) + mem[(i + Words / 2) % Words];
        y = mem[x[WordsLog2+1:2]] + a + b;
        mem[i] = y;
        b = mem[y[2*WordsLog2+1:WordsLog2+2]] + x;
        rsl[i] = b;
      end
      bb = b;
      aa = a;
    endfunction

    function void reseed(logic [31:0] s);
      logic [31:0] v[8];
      rsl[0] = s;
      for (int i = 1; i < Words; i++) rsl[i] = (rsl[i-1] + 1) * rsl[i-1];
      aa = '0; bb = '0; cc = '0;
      foreach (v[k]) v[k] = Golden;
      for (int k = 0; k < 4; k++) scramble(v);
      for (int i = 0; i < Words; i += 8) begin
        for (int k = 0; k < 8; k++) v[k] += rsl[i+k];
        scramble(v);
        for (int k = 0; k < 8; k++) mem[i+k] = v[k];
      end
      for (int i = 0; i < Words; i += 8) begin
        for (int k = 0; k < 8; k++) v[k] += mem[i+k];
        scramble(v);
        for (int k = 0; k < 8; k++) mem[i+k] = v[k];
      end
      next_round();
      left = Words;
    endfunction

    function void note_command(func_t f, logic [31:0] s);
      if (f == FUNC_SEED) begin
        reseed(s);
      end else begin
        if (left == 0) begin
          next_round();
          left = Words - 1;
        end else begin
          left--;
        end
        pending_words.push_back(rsl[left]);
      end
    endfunction

    task check_word(logic [31:0] got);
      logic [31:0] want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", got));
      end else begin
        want = pending_words.pop_front();
        if (got !== want)
          report_mismatch($sformatf("random_value %h, expected %h", got, want));
      end
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_func = 1'b0;
  logic [31:0] in_seed_value = '0;
  logic busy, out_valid;
  logic [31:0] out_random_value;

  isaac_scoreboard words_sb = new();
  int unsigned idle_pct = 0;
  int unsigned quiet_cycles = 0;

  isaac_random_generator_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_seed_value(in_seed_value),
    .out_valid(out_valid),
    .out_random_value(out_random_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) words_sb.note_command(func_t'(in_func), in_seed_value);
      if (out_valid) words_sb.check_word(out_random_value);
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Issues one command beat, idling first at the current rate.
  task automatic send_command(func_t f, logic [31:0] s);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_seed_value <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (words_sb.pending_words.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  initial begin
    logic [31:0] s;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first unseeded draw runs a round on zero memory.
    send_command(FUNC_DRAW, '0);
    send_command(FUNC_DRAW, '0);
    send_command(FUNC_SEED, '0);
    send_command(FUNC_DRAW, '0);
    send_command(FUNC_SEED, 32'hffffffff);
    send_command(FUNC_DRAW, '0);
    send_command(FUNC_DRAW, 32'hffffffff);
    send_command(FUNC_SEED, 32'h80000000);
    send_command(FUNC_DRAW, 32'h5a5a5a5a);
    send_command(FUNC_SEED, 32'h00000001);
    send_command(FUNC_SEED, 32'h9e3779b9);
    send_command(FUNC_DRAW, '0);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 53 : (phase == 3) ? 31 : 0;
      for (int n = 0; n < 435; n++) begin
        s = $urandom();
        if ($urandom_range(99) < 2) send_command(FUNC_SEED, s);
        else send_command(FUNC_DRAW, s);
      end
      drain();
    end

    if (words_sb.errors == 0 && words_sb.pending_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
